>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and an active-low reset.
`define MI4_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Clocked assertion on clk_i and rst_ni.
`define MI4_ASSERT(lbl, prop) `MI4_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

>>> rtl/mi4_pkg.sv
package mi4_pkg;

  localparam int VALUE_W = 32;
  localparam int INDEX_W = 4;

  typedef enum logic [1:0] {
    MA_ELEM,
    MA_PLO,
    MA_PHI,
    MA_COF
  } mul_sel_e;

  typedef struct packed {
    logic               wr_en;
    logic [INDEX_W-1:0] wr_addr;
    logic               rd_en;
    logic [INDEX_W-1:0] rd_addr;
    logic               a_ld;
    logic               mul_en;
    mul_sel_e           mul_sel;
    logic [1:0]         limb;
    logic               prod_ld;
    logic               acc_clr;
    logic               acc_add;
    logic               det_clr;
    logic               det_add;
    logic               add_sub;
    logic [1:0]         add_shift;
    logic               det_fin;
    logic               div_init;
    logic               div_step;
    logic               out_ld;
    logic [INDEX_W-1:0] out_index;
    logic               out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic singular;
  } dp_sts_t;

  // Column order of the six terms of a 3x3 determinant; the first three are positive.
  function automatic logic [1:0] perm3(input logic [2:0] prod, input logic [1:0] pos);
    logic [1:0] m;
    case (prod)
      3'd0: m = pos;
      3'd1: m = (pos == 2'd2) ? 2'd0 : pos + 2'd1;
      3'd2: m = (pos == 2'd0) ? 2'd2 : pos - 2'd1;
      3'd3: m = (pos == 2'd0) ? 2'd0 : ((pos == 2'd1) ? 2'd2 : 2'd1);
      3'd4: m = (pos == 2'd0) ? 2'd1 : ((pos == 2'd1) ? 2'd0 : 2'd2);
      default: m = 2'd2 - pos;
    endcase
    return m;
  endfunction

  // Element index for one factor of one term of the minor that gives a cofactor.
  function automatic logic [INDEX_W-1:0] elem_addr(input logic [INDEX_W-1:0] cof_idx,
                                                   input logic [2:0] prod,
                                                   input logic [1:0] pos);
    logic [1:0] r;
    logic [1:0] c;
    logic [1:0] m;
    logic [1:0] row;
    logic [1:0] col;
    r   = cof_idx[1:0];
    c   = cof_idx[3:2];
    m   = perm3(prod, pos);
    row = (pos >= c) ? pos + 2'd1 : pos;
    col = (m >= r) ? m + 2'd1 : m;
    return {col, row};
  endfunction

endpackage

>>> rtl/mi4_in_if.sv
interface mi4_in_if;
  logic                         valid;
  logic                         ready;
  logic [mi4_pkg::VALUE_W-1:0]  element_value;

  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

>>> rtl/mi4_out_if.sv
interface mi4_out_if;
  logic                         valid;
  logic                         ready;
  logic [mi4_pkg::VALUE_W-1:0]  result_value;
  logic [mi4_pkg::INDEX_W-1:0]  result_index;
  logic                         last_result;
  logic                         singular;
  logic                         saturated;

  modport source (output valid, output result_value, output result_index,
                  output last_result, output singular, output saturated, input ready);
  modport sink (input valid, input result_value, input result_index,
                input last_result, input singular, input saturated, output ready);
endinterface

>>> rtl/mi4_ctrl.sv
module mi4_ctrl #(
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  input  mi4_pkg::dp_sts_t sts_i,
  output mi4_pkg::dp_cmd_t cmd_o
);

  localparam int BW = $clog2(ELEMENT_WIDTH);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PROD,
    ST_DETM,
    ST_DETFIN,
    ST_START,
    ST_DINIT,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                      state_q, state_d;
  logic [mi4_pkg::INDEX_W-1:0] load_cnt_q, load_cnt_d;
  logic [mi4_pkg::INDEX_W-1:0] cof_q, cof_d;
  logic [2:0]                  prod_q, prod_d;
  logic [2:0]                  step_q, step_d;
  logic                        det_phase_q, det_phase_d;
  logic [BW-1:0]               bit_q, bit_d;
  logic                        out_valid_q, out_valid_d;
  logic                        sub;
  logic                        out_free;

  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    cof_d       = cof_q;
    prod_d      = prod_q;
    step_d      = step_q;
    det_phase_d = det_phase_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    sub         = (prod_q >= 3'd3) ^ cof_q[0] ^ cof_q[2];
    out_free    = !out_valid_q || out_ready_i;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = load_cnt_q;
          load_cnt_d    = load_cnt_q + 4'd1;
          if (load_cnt_q == 4'd15) begin
            cmd_o.det_clr = 1'b1;
            cof_d         = '0;
            prod_d        = '0;
            step_d        = '0;
            det_phase_d   = 1'b1;
            state_d       = ST_PROD;
          end
        end
      end
      ST_PROD: begin
        cmd_o.add_sub = sub;
        step_d        = step_q + 3'd1;
        case (step_q)
          3'd0: begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_addr = mi4_pkg::elem_addr(cof_q, prod_q, 2'd0);
            cmd_o.acc_clr = (prod_q == 3'd0);
          end
          3'd1: begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_addr = mi4_pkg::elem_addr(cof_q, prod_q, 2'd1);
            cmd_o.a_ld    = 1'b1;
          end
          3'd2: begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_addr = mi4_pkg::elem_addr(cof_q, prod_q, 2'd2);
            cmd_o.mul_en  = 1'b1;
            cmd_o.mul_sel = mi4_pkg::MA_ELEM;
          end
          3'd3: begin
            cmd_o.prod_ld = 1'b1;
          end
          3'd4: begin
            cmd_o.mul_en  = 1'b1;
            cmd_o.mul_sel = mi4_pkg::MA_PLO;
          end
          3'd5: begin
            cmd_o.mul_en  = 1'b1;
            cmd_o.mul_sel = mi4_pkg::MA_PHI;
            cmd_o.acc_add = 1'b1;
          end
          default: begin
            cmd_o.acc_add   = 1'b1;
            cmd_o.add_shift = 2'd1;
            step_d          = '0;
            if (prod_q == 3'd5) begin
              prod_d  = '0;
              state_d = det_phase_q ? ST_DETM : ST_DINIT;
            end else begin
              prod_d = prod_q + 3'd1;
            end
          end
        endcase
      end
      ST_DETM: begin
        step_d = step_q + 3'd1;
        case (step_q)
          3'd0: begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_addr = {2'b00, cof_q[3:2]};
          end
          3'd1: begin
            cmd_o.mul_en  = 1'b1;
            cmd_o.mul_sel = mi4_pkg::MA_COF;
            cmd_o.limb    = 2'd0;
          end
          3'd2: begin
            cmd_o.mul_en    = 1'b1;
            cmd_o.mul_sel   = mi4_pkg::MA_COF;
            cmd_o.limb      = 2'd1;
            cmd_o.det_add   = 1'b1;
            cmd_o.add_shift = 2'd0;
          end
          3'd3: begin
            cmd_o.mul_en    = 1'b1;
            cmd_o.mul_sel   = mi4_pkg::MA_COF;
            cmd_o.limb      = 2'd2;
            cmd_o.det_add   = 1'b1;
            cmd_o.add_shift = 2'd1;
          end
          3'd4: begin
            cmd_o.mul_en    = 1'b1;
            cmd_o.mul_sel   = mi4_pkg::MA_COF;
            cmd_o.limb      = 2'd3;
            cmd_o.det_add   = 1'b1;
            cmd_o.add_shift = 2'd2;
          end
          default: begin
            cmd_o.det_add   = 1'b1;
            cmd_o.add_shift = 2'd3;
            step_d          = '0;
            if (cof_q == 4'd12) begin
              state_d = ST_DETFIN;
            end else begin
              cof_d   = cof_q + 4'd4;
              state_d = ST_PROD;
            end
          end
        endcase
      end
      ST_DETFIN: begin
        cmd_o.det_fin = 1'b1;
        cof_d         = '0;
        det_phase_d   = 1'b0;
        state_d       = ST_START;
      end
      ST_START: begin
        state_d = sts_i.singular ? ST_EMIT : ST_PROD;
      end
      ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        bit_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        bit_d          = bit_q + 1'b1;
        if (bit_q == BW'(ELEMENT_WIDTH - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.out_ld    = 1'b1;
          cmd_o.out_index = cof_q;
          cmd_o.out_last  = (cof_q == 4'd15);
          out_valid_d     = 1'b1;
          if (cof_q == 4'd15) begin
            state_d = ST_LOAD;
          end else begin
            cof_d   = cof_q + 4'd1;
            prod_d  = '0;
            step_d  = '0;
            state_d = sts_i.singular ? ST_EMIT : ST_PROD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_cnt_q  <= '0;
      cof_q       <= '0;
      prod_q      <= '0;
      step_q      <= '0;
      det_phase_q <= 1'b0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      cof_q       <= cof_d;
      prod_q      <= prod_d;
      step_q      <= step_d;
      det_phase_q <= det_phase_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/mi4_dp.sv
module mi4_dp #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRAC_BITS     = 16
) (
  input  logic                        clk_i,
  input  logic [mi4_pkg::VALUE_W-1:0] element_value_i,
  input  mi4_pkg::dp_cmd_t            cmd_i,
  output mi4_pkg::dp_sts_t            sts_o,
  output logic [mi4_pkg::VALUE_W-1:0] result_value_o,
  output logic [mi4_pkg::INDEX_W-1:0] result_index_o,
  output logic                        last_result_o,
  output logic                        singular_o,
  output logic                        saturated_o
);

  localparam int W  = ELEMENT_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int CW = 3 * W + 2;
  localparam int DW = 4 * W + 2;
  localparam int NW = CW + 2 * F;
  localparam int HW = NW - W;
  localparam int XW = (HW > DW) ? HW : DW;

  logic        [W-1:0]    mem_q [16];
  logic signed [W-1:0]    elem_q;
  logic signed [W-1:0]    a_q;
  logic signed [2*W:0]    pp_q;
  logic signed [2*W-1:0]  prod_q;
  logic signed [CW-1:0]   acc_q;
  logic signed [DW-1:0]   det_q;
  logic        [DW-1:0]   det_abs_q;
  logic                   det_neg_q;
  logic                   sing_q;
  logic        [DW-1:0]   rem_q;
  logic        [W-1:0]    low_q;
  logic        [W-1:0]    quo_q;
  logic                   over_q;
  logic                   neg_q;

  logic [mi4_pkg::VALUE_W-1:0] res_value_q;
  logic [mi4_pkg::INDEX_W-1:0] res_index_q;
  logic                        res_last_q;
  logic                        res_sing_q;
  logic                        res_sat_q;

  logic signed [W:0]      mul_a;
  logic signed [2*W:0]    mul_p;
  logic signed [CW-1:0]   acc_ext;
  logic signed [CW-1:0]   acc_term;
  logic signed [DW-1:0]   det_ext;
  logic signed [DW-1:0]   det_term;
  logic                   cneg;
  logic        [CW-1:0]   cmag;
  logic        [NW-1:0]   num;
  logic        [XW-1:0]   hi_x;
  logic        [DW:0]     rem2;
  logic        [DW:0]     rem_diff;
  logic                   ge;
  logic                   clamp;
  logic        [W-1:0]    qc;
  logic        [W-1:0]    sv;

  always_comb begin
    case (cmd_i.mul_sel)
      mi4_pkg::MA_ELEM: mul_a = {a_q[W-1], a_q};
      mi4_pkg::MA_PLO:  mul_a = {1'b0, prod_q[W-1:0]};
      mi4_pkg::MA_PHI:  mul_a = {prod_q[2*W-1], prod_q[2*W-1:W]};
      default: begin
        case (cmd_i.limb)
          2'd0:    mul_a = {1'b0, acc_q[W-1:0]};
          2'd1:    mul_a = {1'b0, acc_q[2*W-1:W]};
          2'd2:    mul_a = {1'b0, acc_q[3*W-1:2*W]};
          default: mul_a = {{(W-1){acc_q[CW-1]}}, acc_q[CW-1:3*W]};
        endcase
      end
    endcase
  end

  assign mul_p = mul_a * elem_q;

  always_comb begin
    acc_ext  = CW'(pp_q);
    acc_term = cmd_i.add_shift[0] ? (acc_ext << W) : acc_ext;
    det_ext  = DW'(pp_q);
    case (cmd_i.add_shift)
      2'd0:    det_term = det_ext;
      2'd1:    det_term = det_ext << W;
      2'd2:    det_term = det_ext << (2 * W);
      default: det_term = det_ext << (3 * W);
    endcase
  end

  always_comb begin
    cneg     = acc_q[CW-1];
    cmag     = cneg ? CW'(-acc_q) : CW'(acc_q);
    num      = NW'(cmag) << (2 * F);
    hi_x     = XW'(num[NW-1:W]);
    rem2     = {rem_q, low_q[W-1]};
    ge       = rem2 >= {1'b0, det_abs_q};
    rem_diff = ge ? (rem2 - {1'b0, det_abs_q}) : rem2;
    clamp    = over_q || (neg_q ? (quo_q[W-1] && (|quo_q[W-2:0])) : quo_q[W-1]);
    if (clamp) begin
      qc = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      qc = quo_q;
    end
    sv = neg_q ? (~qc + 1'b1) : qc;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= element_value_i[W-1:0];
    end
    if (cmd_i.rd_en) begin
      elem_q <= mem_q[cmd_i.rd_addr];
    end
    if (cmd_i.a_ld) begin
      a_q <= elem_q;
    end
    if (cmd_i.mul_en) begin
      pp_q <= mul_p;
    end
    if (cmd_i.prod_ld) begin
      prod_q <= pp_q[2*W-1:0];
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= cmd_i.add_sub ? (acc_q - acc_term) : (acc_q + acc_term);
    end
    if (cmd_i.det_clr) begin
      det_q <= '0;
    end else if (cmd_i.det_add) begin
      det_q <= det_q + det_term;
    end
    if (cmd_i.det_fin) begin
      det_neg_q <= det_q[DW-1];
      det_abs_q <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      sing_q    <= (det_q == '0);
    end
    if (cmd_i.div_init) begin
      over_q <= hi_x >= XW'(det_abs_q);
      rem_q  <= hi_x[DW-1:0];
      low_q  <= num[W-1:0];
      quo_q  <= '0;
      neg_q  <= cneg ^ det_neg_q;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_diff[DW-1:0];
      low_q <= {low_q[W-2:0], 1'b0};
      quo_q <= {quo_q[W-2:0], ge};
    end
    if (cmd_i.out_ld) begin
      res_value_q <= sing_q ? '0 : mi4_pkg::VALUE_W'($signed(sv));
      res_index_q <= cmd_i.out_index;
      res_last_q  <= cmd_i.out_last;
      res_sing_q  <= sing_q;
      res_sat_q   <= !sing_q && clamp;
    end
  end

  assign sts_o.singular = sing_q;
  assign result_value_o = res_value_q;
  assign result_index_o = res_index_q;
  assign last_result_o  = res_last_q;
  assign singular_o     = res_sing_q;
  assign saturated_o    = res_sat_q;

endmodule

>>> rtl/matrix_inverse_4x4_core.sv
// Elements load one per cycle in the load state; the sixteenth load starts a run that emits 16 results.
// Each cofactor is built from six triple products on one shared multiplier.
// After the determinant, each cofactor is divided by it, one quotient bit per cycle in the divider.
// A singular matrix gives its 16 results right after the determinant, one per cycle while res_o.ready is high.
// Reset clears the controller and load position; the element store needs no reset.
module matrix_inverse_4x4_core #(
  parameter int FRAC_BITS     = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  mi4_in_if.sink    elem_i,
  mi4_out_if.source res_o
);

  mi4_pkg::dp_cmd_t cmd;
  mi4_pkg::dp_sts_t sts;

  mi4_ctrl #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (elem_i.valid),
    .in_ready_o  (elem_i.ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mi4_dp #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .element_value_i (elem_i.element_value),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .result_value_o  (res_o.result_value),
    .result_index_o  (res_o.result_index),
    .last_result_o   (res_o.last_result),
    .singular_o      (res_o.singular),
    .saturated_o     (res_o.saturated)
  );

endmodule

>>> rtl/mi4_checker.sv
`include "assert_macros.svh"

module mi4_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [mi4_pkg::VALUE_W-1:0] result_value_i,
  input logic [mi4_pkg::INDEX_W-1:0] result_index_i,
  input logic                        last_result_i,
  input logic                        singular_i,
  input logic                        saturated_i
);

  logic [mi4_pkg::VALUE_W+mi4_pkg::INDEX_W+2:0] out_payload;

  assign out_payload = {result_value_i, result_index_i, last_result_i, singular_i, saturated_i};

  `MI4_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload))
  `MI4_ASSERT(a_last_index, out_valid_i |-> (last_result_i == (result_index_i == 4'd15)))
  `MI4_ASSERT(a_singular_zero, out_valid_i && singular_i |-> (result_value_i == '0) && !saturated_i)
  `MI4_ASSERT(a_busy_in_run, out_valid_i && !last_result_i |-> !in_ready_i)

endmodule

bind matrix_inverse_4x4_core mi4_checker u_mi4_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (elem_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .result_value_i (res_o.result_value),
  .result_index_i (res_o.result_index),
  .last_result_i  (res_o.last_result),
  .singular_i     (res_o.singular),
  .saturated_i    (res_o.saturated)
);
